// File: rtl/chcc_pkg.sv
package chcc_pkg;

   localparam int HOUR_W     = 5;
   localparam int SAVED_W    = 8;
   localparam int MIN_W      = 6;
   localparam int SEC_W      = 6;
   localparam int DIAL_W     = 4;
   localparam int HDIFF_W    = 3;
   localparam int MINS_W     = 9;
   localparam int SECS_W     = 15;
   localparam int STEP_W     = 20;
   localparam int COMP_W     = 6;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic DIR_CW  = 1'b0;
   localparam logic DIR_CCW = 1'b1;

   localparam int DIAL_HOURS     = 12;
   localparam int HALF_DIAL      = 6;
   localparam int DAY_HOURS      = 24;
   localparam int MAX_SAVED_HOUR = 24;
   localparam int PER_MINUTE     = 60;
   localparam int STEPS_PER_SEC  = 22;
   localparam int QUARTER_SHIFT  = 2;

   localparam logic [COMP_W-1:0] COMP_RESET = COMP_W'(5);

   // register index, taken from the word address of the bus
   localparam logic [CSR_ADDR_W-3:0] REG_COMPENSATION = '0;

   typedef struct packed {
      logic [SAVED_W-1:0] saved_hour_byte;
      logic [MIN_W-1:0]   saved_minute;
      logic [SEC_W-1:0]   saved_second;
      logic [HOUR_W-1:0]  current_hour;
      logic [MIN_W-1:0]   current_minute;
      logic [SEC_W-1:0]   current_second;
   } chcc_req_type;

   typedef struct packed {
      logic              status;
      logic              direction;
      logic [SECS_W-1:0] seconds_to_move;
      logic [STEP_W-1:0] step_count;
   } chcc_rsp_type;

   typedef struct packed {
      logic              error;
      logic              direction;
      logic [MINS_W-1:0] minutes;
      logic [SEC_W-1:0]  saved_second;
      logic [SEC_W-1:0]  current_second;
   } chcc_mins_type;

   typedef struct packed {
      logic              error;
      logic              direction;
      logic [SECS_W-1:0] seconds;
   } chcc_secs_type;

endpackage

// File: rtl/chcc_csr.sv
module chcc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [chcc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [chcc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [chcc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output logic [chcc_pkg::COMP_W-1:0]         compensation
);
   import chcc_pkg::*;

   logic [COMP_W-1:0]     comp_ff;
   logic [COMP_W-1:0]     comp_in;
   logic [CSR_ADDR_W-3:0] reg_index;
   logic                  write_en;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      comp_in = comp_ff;
      unique case (reg_index)
         REG_COMPENSATION: begin
            if (write_en) begin
               comp_in = csr_pwdata[COMP_W-1:0];
            end
            csr_prdata = CSR_DATA_W'(comp_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff <= COMP_RESET;
      end else begin
         comp_ff <= comp_in;
      end
   end

   assign compensation = comp_ff;

endmodule

// File: rtl/chcc_dial.sv
module chcc_dial (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  chcc_pkg::chcc_req_type  in_data,
   output logic                    out_valid,
   input  logic                    out_stall,
   output chcc_pkg::chcc_mins_type out_data
);
   import chcc_pkg::*;

   function automatic logic [DIAL_W-1:0] fold_dial(input logic [HOUR_W-1:0] h);
      logic [DIAL_W-1:0] r;
      if (h == '0) begin
         r = DIAL_W'(DIAL_HOURS);
      end else if (h > HOUR_W'(DIAL_HOURS)) begin
         r = DIAL_W'(h - HOUR_W'(DIAL_HOURS));
      end else begin
         r = h[DIAL_W-1:0];
      end
      return r;
   endfunction

   // hour stage
   logic               v1_ff;
   logic               err1_ff, err1_in;
   logic               dir1_ff, dir1_in;
   logic [HDIFF_W-1:0] hd1_ff, hd1_in;
   logic [MIN_W-1:0]   sm1_ff, cm1_ff;
   logic [SEC_W-1:0]   ss1_ff, cs1_ff;

   // minute stage
   logic               v2_ff;
   chcc_mins_type      mins2_ff, mins2_in;

   logic               en1, en2;
   logic [6:0]         saved_hour;
   logic [HOUR_W-1:0]  cur_hour;
   logic [DIAL_W-1:0]  sh_dial, ch_dial, hdiff;
   logic [MINS_W-1:0]  mins_base;
   logic [MIN_W-1:0]   mdiff;

   assign en2      = !v2_ff || !out_stall;
   assign en1      = !v1_ff || en2;
   assign in_stall = !en1;

   always_comb begin
      saved_hour = in_data.saved_hour_byte[6:0];
      err1_in    = saved_hour > 7'(MAX_SAVED_HOUR);
      cur_hour   = (in_data.current_hour >= HOUR_W'(DAY_HOURS)) ?
                   in_data.current_hour - HOUR_W'(DAY_HOURS) : in_data.current_hour;
      sh_dial    = fold_dial(saved_hour[HOUR_W-1:0]);
      ch_dial    = fold_dial(cur_hour);
      hdiff      = (ch_dial >= sh_dial) ? ch_dial - sh_dial : sh_dial - ch_dial;
      // go the short way round once half the dial is reached
      if (hdiff >= DIAL_W'(HALF_DIAL)) begin
         hd1_in  = HDIFF_W'(DIAL_W'(DIAL_HOURS) - hdiff);
         dir1_in = (ch_dial > sh_dial) ? DIR_CCW : DIR_CW;
      end else begin
         hd1_in  = hdiff[HDIFF_W-1:0];
         dir1_in = (ch_dial >= sh_dial) ? DIR_CW : DIR_CCW;
      end
   end

   always_comb begin
      mins_base              = MINS_W'(hd1_ff) * MINS_W'(PER_MINUTE);
      mdiff                  = (cm1_ff >= sm1_ff) ? cm1_ff - sm1_ff : sm1_ff - cm1_ff;
      mins2_in.error         = err1_ff;
      mins2_in.saved_second  = ss1_ff;
      mins2_in.current_second = cs1_ff;
      mins2_in.direction     = dir1_ff;
      if ((dir1_ff == DIR_CW) == (cm1_ff >= sm1_ff)) begin
         mins2_in.minutes = mins_base + MINS_W'(mdiff);
      end else begin
         // nothing left to take from: reverse instead
         if (mins_base == '0) begin
            mins2_in.direction = !dir1_ff;
         end
         mins2_in.minutes = (mins_base >= MINS_W'(mdiff)) ?
                            mins_base - MINS_W'(mdiff) : MINS_W'(mdiff) - mins_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         err1_ff <= err1_in;
         dir1_ff <= dir1_in;
         hd1_ff  <= hd1_in;
         sm1_ff  <= in_data.saved_minute;
         cm1_ff  <= in_data.current_minute;
         ss1_ff  <= in_data.saved_second;
         cs1_ff  <= in_data.current_second;
      end
      if (en2 && v1_ff) begin
         mins2_ff <= mins2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = mins2_ff;

endmodule

// File: rtl/chcc_secs.sv
module chcc_secs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [chcc_pkg::COMP_W-1:0] compensation,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  chcc_pkg::chcc_mins_type     in_data,
   output logic                        out_valid,
   input  logic                        out_stall,
   output chcc_pkg::chcc_secs_type     out_data
);
   import chcc_pkg::*;

   logic          v3_ff, v4_ff;
   chcc_secs_type secs3_ff, secs3_in;
   chcc_secs_type secs4_ff, secs4_in;
   logic          en3, en4;
   logic [SECS_W-1:0] secs_base;
   logic [SEC_W-1:0]  sdiff;

   assign en4      = !v4_ff || !out_stall;
   assign en3      = !v3_ff || en4;
   assign in_stall = !en3;

   always_comb begin
      secs_base          = SECS_W'(in_data.minutes) * SECS_W'(PER_MINUTE);
      sdiff              = (in_data.current_second >= in_data.saved_second) ?
                           in_data.current_second - in_data.saved_second :
                           in_data.saved_second - in_data.current_second;
      secs3_in.error     = in_data.error;
      secs3_in.direction = in_data.direction;
      if ((in_data.direction == DIR_CW) ==
          (in_data.saved_second <= in_data.current_second)) begin
         secs3_in.seconds = secs_base + SECS_W'(sdiff);
      end else begin
         if (secs_base == '0) begin
            secs3_in.direction = !in_data.direction;
         end
         secs3_in.seconds = (secs_base >= SECS_W'(sdiff)) ?
                            secs_base - SECS_W'(sdiff) : SECS_W'(sdiff) - secs_base;
      end
   end

   always_comb begin
      secs4_in.error     = secs3_ff.error;
      secs4_in.direction = secs3_ff.direction;
      if (secs3_ff.error) begin
         secs4_in.direction = DIR_CW;
         secs4_in.seconds   = '0;
      end else if (secs3_ff.direction == DIR_CW) begin
         secs4_in.seconds = secs3_ff.seconds + SECS_W'(compensation);
      end else begin
         // clamp at zero rather than wrap
         secs4_in.seconds = (secs3_ff.seconds >= SECS_W'(compensation)) ?
                            secs3_ff.seconds - SECS_W'(compensation) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en3) begin
            v3_ff <= in_valid;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && in_valid) begin
         secs3_ff <= secs3_in;
      end
      if (en4 && v3_ff) begin
         secs4_ff <= secs4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = secs4_ff;

endmodule

// File: rtl/chcc_step.sv
module chcc_step (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  chcc_pkg::chcc_secs_type in_data,
   output logic                    out_valid,
   input  logic                    out_stall,
   output chcc_pkg::chcc_rsp_type  out_data
);
   import chcc_pkg::*;

   logic         v5_ff;
   chcc_rsp_type rsp_ff, rsp_in;
   logic         en5;

   assign en5      = !v5_ff || !out_stall;
   assign in_stall = !en5;

   always_comb begin
      rsp_in.status          = in_data.error;
      rsp_in.direction       = in_data.direction;
      rsp_in.seconds_to_move = in_data.seconds;
      // 22.25 microsteps per dial second
      rsp_in.step_count      = STEP_W'(in_data.seconds) * STEP_W'(STEPS_PER_SEC) +
                               STEP_W'(in_data.seconds >> QUARTER_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en5) begin
         v5_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en5 && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = rsp_ff;

endmodule

// File: rtl/clock_hand_catchup_calculator.sv
// Works out how far and which way a 12-hour stepper dial must move to catch
// up from a saved time to the current time: direction, dial seconds after the
// compensation register is applied, and microsteps (seconds times 22.25).
// A saved hour above 24 (recovery flag in bit 7 ignored) returns status 1 with
// all other fields zero. Five register stages (hours, minutes, seconds,
// compensation, step count); rsp_valid rises once a request has passed
// through all five. A new request is taken every cycle while req_stall is
// low; req_stall rises only when all five stages hold a request and
// rsp_stall is high, and while the output is stalled the empty stages
// still fill.
// compensation_seconds sits at byte address 0 and resets to 5; write it only
// while no request is in flight.
module clock_hand_catchup_calculator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  chcc_pkg::chcc_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output chcc_pkg::chcc_rsp_type              rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [chcc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [chcc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [chcc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import chcc_pkg::*;

   logic [COMP_W-1:0] compensation;
   chcc_mins_type     mins_data;
   chcc_secs_type     secs_data;
   logic              mins_valid, mins_stall;
   logic              secs_valid, secs_stall;

   chcc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .compensation (compensation)
   );

   chcc_dial u_dial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (mins_valid),
      .out_stall (mins_stall),
      .out_data  (mins_data)
   );

   chcc_secs u_secs (
      .clock        (clock),
      .reset        (reset),
      .compensation (compensation),
      .in_valid     (mins_valid),
      .in_stall     (mins_stall),
      .in_data      (mins_data),
      .out_valid    (secs_valid),
      .out_stall    (secs_stall),
      .out_data     (secs_data)
   );

   chcc_step u_step (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (secs_valid),
      .in_stall  (secs_stall),
      .in_data   (secs_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   // an error result carries nothing else
   a_error_fields_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.direction == DIR_CW && rsp_data.seconds_to_move == '0 &&
         rsp_data.step_count == '0)
      else $error("error result with nonzero fields");

   // microstep count agrees with the dial seconds
   a_step_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.step_count ==
            STEP_W'(rsp_data.seconds_to_move) * STEP_W'(STEPS_PER_SEC) +
            STEP_W'(rsp_data.seconds_to_move >> QUARTER_SHIFT))
      else $error("step count mismatch");

   // the input can only be held back by a result waiting at the output
   a_stall_source : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with output free");

   // seconds never exceed six hours plus stray minute and second values and the largest compensation
   a_seconds_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.seconds_to_move <= SECS_W'(25506))
      else $error("seconds out of range");

endmodule

// File: dv/clock_hand_catchup_calculator_tb.sv
`timescale 1ns / 1ps

module clock_hand_catchup_calculator_tb;
   import chcc_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 12;
   localparam int HOLD_OFF_CYCLES = 120;
   localparam int BATCH_ITEMS     = 100;
   localparam int N_DIRECTED      = 20;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;
   localparam logic TYPED        = 1'b1;
   localparam logic PREDICTED    = 1'b0;

   localparam logic [CSR_ADDR_W-1:0] COMP_ADDR = {REG_COMPENSATION, 2'b00};

   localparam chcc_rsp_type NO_RESULT    = '0;
   localparam chcc_rsp_type ERROR_RESULT = {STATUS_ERROR, DIR_CW, 15'd0, 20'd0};
   // hands already aligned: only the reset compensation of five seconds moves the dial
   localparam chcc_rsp_type ALIGNED_RESULT = {STATUS_OK, DIR_CW, 15'd5, 20'd111};
   localparam chcc_rsp_type CLAMPED_RESULT = {STATUS_OK, DIR_CCW, 15'd0, 20'd0};

   typedef struct packed {
      chcc_req_type req;
      logic         kind;
      chcc_rsp_type res;
   } directed_row_type;

   // saved hour byte, saved min, saved sec, current hour, current min, current sec
   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      {8'd0,   6'd0,  6'd0,  5'd0,  6'd0,  6'd0,  TYPED,     ALIGNED_RESULT},
      {8'h80,  6'd0,  6'd0,  5'd0,  6'd0,  6'd0,  TYPED,     ALIGNED_RESULT},
      {8'd25,  6'd0,  6'd0,  5'd0,  6'd0,  6'd0,  TYPED,     ERROR_RESULT},
      {8'h99,  6'd0,  6'd0,  5'd0,  6'd0,  6'd0,  TYPED,     ERROR_RESULT},
      {8'hFF,  6'd63, 6'd63, 5'd31, 6'd63, 6'd63, TYPED,     ERROR_RESULT},
      {8'h7F,  6'd0,  6'd0,  5'd0,  6'd0,  6'd0,  TYPED,     ERROR_RESULT},
      {8'd24,  6'd0,  6'd0,  5'd12, 6'd0,  6'd0,  TYPED,     ALIGNED_RESULT},
      {8'h98,  6'd0,  6'd0,  5'd0,  6'd0,  6'd0,  TYPED,     ALIGNED_RESULT},
      {8'd12,  6'd0,  6'd0,  5'd24, 6'd0,  6'd0,  PREDICTED, NO_RESULT},
      {8'd7,   6'd30, 6'd30, 5'd31, 6'd30, 6'd30, PREDICTED, NO_RESULT},
      {8'd6,   6'd0,  6'd0,  5'd0,  6'd0,  6'd0,  PREDICTED, NO_RESULT},
      {8'd0,   6'd0,  6'd0,  5'd6,  6'd0,  6'd0,  PREDICTED, NO_RESULT},
      {8'd1,   6'd63, 6'd63, 5'd1,  6'd0,  6'd0,  PREDICTED, NO_RESULT},
      {8'd3,   6'd10, 6'd30, 5'd3,  6'd10, 6'd0,  PREDICTED, NO_RESULT},
      {8'd3,   6'd10, 6'd2,  5'd3,  6'd10, 6'd0,  TYPED,     CLAMPED_RESULT},
      {8'd12,  6'd0,  6'd0,  5'd17, 6'd59, 6'd59, PREDICTED, NO_RESULT},
      {8'd23,  6'd59, 6'd59, 5'd5,  6'd0,  6'd0,  PREDICTED, NO_RESULT},
      {8'd9,   6'd15, 6'd40, 5'd20, 6'd45, 6'd10, PREDICTED, NO_RESULT},
      {8'd0,   6'd60, 6'd61, 5'd23, 6'd62, 6'd63, PREDICTED, NO_RESULT},
      {8'd18,  6'd0,  6'd0,  5'd0,  6'd0,  6'd0,  PREDICTED, NO_RESULT}
   };

   localparam logic [CSR_DATA_W-1:0] COMP_PLAN [6] = '{
      32'd0, 32'd63, 32'd59, 32'hA5A5_A5E5, 32'd5, 32'd17
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   chcc_req_type          req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   chcc_rsp_type          rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   chcc_rsp_type      expected_moves [$];
   chcc_rsp_type      due_move;
   logic [COMP_W-1:0] compensation = COMP_RESET;

   int unsigned sender_idle_pct   = 20;
   int unsigned receiver_idle_pct = 77;
   int unsigned hold_off_ticket   = 0;
   int unsigned hold_off_seen     = 0;
   int unsigned hold_off_left     = 0;

   int unsigned cycle_count        = 0;
   int unsigned mismatches         = 0;
   int unsigned requests_sent      = 0;
   int unsigned results_checked    = 0;
   int unsigned error_results      = 0;
   int unsigned comp_writes        = 0;
   int unsigned input_stall_cycles = 0;

   clock_hand_catchup_calculator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("clock_hand_catchup_calculator test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned span(int unsigned a, int unsigned b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic int unsigned dial_hour(int unsigned h);
      if (h == 0)
         return DIAL_HOURS;
      return (h > DIAL_HOURS) ? h - DIAL_HOURS : h;
   endfunction

   function automatic chcc_rsp_type predict_catchup(chcc_req_type r, logic [COMP_W-1:0] comp);
      int unsigned  saved_h, current_h, hours, mins, minute_gap, secs, second_gap;
      logic         dir;
      chcc_rsp_type move;
      move      = '0;
      saved_h   = r.saved_hour_byte[6:0];
      current_h = r.current_hour;
      if (saved_h > MAX_SAVED_HOUR) begin
         move.status = STATUS_ERROR;
         return move;
      end
      if (current_h >= DAY_HOURS)
         current_h -= DAY_HOURS;
      saved_h   = dial_hour(saved_h);
      current_h = dial_hour(current_h);

      // take the shorter way round the dial
      hours = span(current_h, saved_h);
      if (hours >= HALF_DIAL) begin
         hours = DIAL_HOURS - hours;
         dir   = (current_h > saved_h) ? DIR_CCW : DIR_CW;
      end else begin
         dir = (current_h >= saved_h) ? DIR_CW : DIR_CCW;
      end

      // an underflow of an empty remainder turns the hands the other way
      mins       = hours * PER_MINUTE;
      minute_gap = span(r.current_minute, r.saved_minute);
      if ((dir == DIR_CW) == (r.current_minute >= r.saved_minute)) begin
         mins += minute_gap;
      end else begin
         if (mins == 0)
            dir = ~dir;
         mins = span(mins, minute_gap);
      end

      secs       = mins * PER_MINUTE;
      second_gap = span(r.current_second, r.saved_second);
      if ((dir == DIR_CW) == (r.saved_second <= r.current_second)) begin
         secs += second_gap;
      end else begin
         if (secs == 0)
            dir = ~dir;
         secs = span(secs, second_gap);
      end

      if (dir == DIR_CW)
         secs += comp;
      else
         secs = (secs >= comp) ? secs - comp : 0;

      move.status          = STATUS_OK;
      move.direction       = dir;
      move.seconds_to_move = SECS_W'(secs);
      secs                 = move.seconds_to_move;
      move.step_count      = STEP_W'(secs * STEPS_PER_SEC + (secs >> QUARTER_SHIFT));
      return move;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] MISMATCH %s", $realtime, msg);
   endtask

   task automatic compare_field(input string field, input int unsigned got,
                                input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                                   results_checked, field, want, got));
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall)
            input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_moves.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_data));
            end else begin
               due_move = expected_moves.pop_front();
               compare_field("status", rsp_data.status, due_move.status);
               compare_field("direction", rsp_data.direction, due_move.direction);
               compare_field("seconds_to_move", rsp_data.seconds_to_move,
                             due_move.seconds_to_move);
               compare_field("step_count", rsp_data.step_count, due_move.step_count);
               if (due_move.status == STATUS_ERROR)
                  error_results++;
            end
            results_checked++;
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (hold_off_left != 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_seen != hold_off_ticket) begin
         // long hold-off: let the pipeline fill and push back on the requester
         hold_off_seen <= hold_off_ticket;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_stall     <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // ---------------------------------------------------------------- sender

   task automatic issue_catchup(input chcc_req_type r, input logic kind,
                                input chcc_rsp_type typed_move);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct)
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_moves.push_back((kind == TYPED) ? typed_move : predict_catchup(r, compensation));
      requests_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_moves.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [5:0] clock_field();
      return ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
   endfunction

   function automatic chcc_req_type random_request();
      chcc_req_type r;
      int unsigned  roll;
      roll                = $urandom_range(99);
      r.saved_minute      = clock_field();
      r.saved_second      = clock_field();
      r.current_minute    = clock_field();
      r.current_second    = clock_field();
      r.current_hour      = ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                                      : 5'($urandom_range(23));
      if (roll < 12)
         r.saved_hour_byte = 8'($urandom_range(255));
      else
         r.saved_hour_byte = {1'($urandom_range(1)), 7'($urandom_range(MAX_SAVED_HOUR))};
      // close times: same dial hour, so the minute and second underflows and clamps show up
      if (roll >= 65) begin
         r.current_hour = 5'((r.saved_hour_byte[6:0] + DIAL_HOURS * $urandom_range(1))
                             % DAY_HOURS);
         if ($urandom_range(1) == 1)
            r.current_minute = r.saved_minute;
         if ($urandom_range(2) == 0)
            r.current_second = 6'(r.saved_second + $urandom_range(4) - 2);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- register port

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      data = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_compensation();
      logic [CSR_DATA_W-1:0] readback;
      csr_read(COMP_ADDR, readback);
      if (readback !== CSR_DATA_W'(compensation))
         report_mismatch($sformatf("compensation readback: expected %0d, got %h",
                                   compensation, readback));
   endtask

   task automatic set_compensation(input logic [CSR_DATA_W-1:0] word);
      settle();
      csr_write(COMP_ADDR, word);
      compensation = word[COMP_W-1:0];
      comp_writes++;
      // the bus goes idle between the write and the read-back
      @(posedge clock);
      check_compensation();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_compensation();

      for (int i = 0; i < N_DIRECTED; i++)
         issue_catchup(DIRECTED[i].req, DIRECTED[i].kind, DIRECTED[i].res);

      for (int pattern = 0; pattern < 3; pattern++) begin
         case (pattern)
            0: begin
               sender_idle_pct   = 20;
               receiver_idle_pct = 77;
            end
            1: begin
               sender_idle_pct   = 77;
               receiver_idle_pct = 20;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (int half = 0; half < 2; half++) begin
            if (pattern == 1 && half == 1)
               set_compensation(32'($urandom_range(63)));
            else
               set_compensation(COMP_PLAN[2 * pattern + half]);
            if (pattern == 2 && half == 0)
               hold_off_ticket <= hold_off_ticket + 1;
            for (int n = 0; n < BATCH_ITEMS; n++)
               issue_catchup(random_request(), PREDICTED, NO_RESULT);
         end
      end

      settle();
      $display("Sent %0d requests (%0d error codes) over %0d register writes",
               requests_sent, error_results, comp_writes);
      $display("and three idling patterns; checked %0d results; input held off on %0d cycles",
               results_checked, input_stall_cycles);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("clock_hand_catchup_calculator test passed");
      end else begin
         $display("clock_hand_catchup_calculator test failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/chcc_pkg.sv
rtl/chcc_csr.sv
rtl/chcc_dial.sv
rtl/chcc_secs.sv
rtl/chcc_step.sv
rtl/clock_hand_catchup_calculator.sv
dv/clock_hand_catchup_calculator_tb.sv
